/* rtl/core/lnu_pkg.sv */
// Shared constants, exp table and pipeline word type for the LIF neuron update unit.
package lnu_pkg;

  localparam int NEURONS   = 1024;
  localparam int ID_W      = 10;
  localparam int EXP_DEPTH = 256;
  localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
  localparam int EXP_W     = 17;

  // pipelined divider geometry, sized for the implicit-Euler quotient
  localparam int DIV_NUM_W = 44;
  localparam int DIV_DEN_W = 36;
  localparam int DIV_Q_W   = 18;
  localparam int DIV_CMP_W = DIV_DEN_W + DIV_Q_W;

  localparam logic [15:0] G_MAX = 16'd2560;
  localparam logic [15:0] G_ONE = 16'd256;

  localparam logic [1:0] MODE_EXPLICIT = 2'd0;
  localparam logic [1:0] MODE_IMPLICIT = 2'd1;

  localparam logic CMD_INIT = 1'b1;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_REVERSAL  = 3'd1;
  localparam logic [2:0] REG_REST      = 3'd2;
  localparam logic [2:0] REG_DECAYS    = 3'd3;
  localparam logic [2:0] REG_DT_TAU    = 3'd4;
  localparam logic [2:0] REG_TH_DECAY  = 3'd5;

  // Taylor terms of exp(-16/EXP_DEPTH) in Q0.30, each one truncated
  localparam longint EXP_T1  = ((longint'(1) << 30) * 16) / (longint'(EXP_DEPTH) * 1);
  localparam longint EXP_T2  = (EXP_T1 * 16) / (longint'(EXP_DEPTH) * 2);
  localparam longint EXP_T3  = (EXP_T2 * 16) / (longint'(EXP_DEPTH) * 3);
  localparam longint EXP_T4  = (EXP_T3 * 16) / (longint'(EXP_DEPTH) * 4);
  localparam longint EXP_T5  = (EXP_T4 * 16) / (longint'(EXP_DEPTH) * 5);
  localparam longint EXP_T6  = (EXP_T5 * 16) / (longint'(EXP_DEPTH) * 6);
  localparam longint EXP_T7  = (EXP_T6 * 16) / (longint'(EXP_DEPTH) * 7);
  localparam longint EXP_T8  = (EXP_T7 * 16) / (longint'(EXP_DEPTH) * 8);
  localparam longint EXP_T9  = (EXP_T8 * 16) / (longint'(EXP_DEPTH) * 9);
  localparam longint EXP_T10 = (EXP_T9 * 16) / (longint'(EXP_DEPTH) * 10);
  localparam longint EXP_T11 = (EXP_T10 * 16) / (longint'(EXP_DEPTH) * 11);
  localparam longint EXP_T12 = (EXP_T11 * 16) / (longint'(EXP_DEPTH) * 12);
  localparam longint EXP_T13 = (EXP_T12 * 16) / (longint'(EXP_DEPTH) * 13);
  localparam longint EXP_T14 = (EXP_T13 * 16) / (longint'(EXP_DEPTH) * 14);
  localparam longint EXP_T15 = (EXP_T14 * 16) / (longint'(EXP_DEPTH) * 15);
  localparam longint EXP_T16 = (EXP_T15 * 16) / (longint'(EXP_DEPTH) * 16);
  localparam longint EXP_T17 = (EXP_T16 * 16) / (longint'(EXP_DEPTH) * 17);
  localparam longint EXP_T18 = (EXP_T17 * 16) / (longint'(EXP_DEPTH) * 18);
  localparam longint EXP_T19 = (EXP_T18 * 16) / (longint'(EXP_DEPTH) * 19);
  localparam longint EXP_T20 = (EXP_T19 * 16) / (longint'(EXP_DEPTH) * 20);
  localparam longint EXP_T21 = (EXP_T20 * 16) / (longint'(EXP_DEPTH) * 21);
  localparam longint EXP_T22 = (EXP_T21 * 16) / (longint'(EXP_DEPTH) * 22);
  localparam longint EXP_T23 = (EXP_T22 * 16) / (longint'(EXP_DEPTH) * 23);
  localparam longint EXP_T24 = (EXP_T23 * 16) / (longint'(EXP_DEPTH) * 24);

  localparam longint EXP_BASE = (longint'(1) << 30)
                              - EXP_T1  + EXP_T2  - EXP_T3  + EXP_T4  - EXP_T5  + EXP_T6
                              - EXP_T7  + EXP_T8  - EXP_T9  + EXP_T10 - EXP_T11 + EXP_T12
                              - EXP_T13 + EXP_T14 - EXP_T15 + EXP_T16 - EXP_T17 + EXP_T18
                              - EXP_T19 + EXP_T20 - EXP_T21 + EXP_T22 - EXP_T23 + EXP_T24;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_DEPTH];

  // exp(-16*i/EXP_DEPTH) in Q1.16, built from a truncated Taylor base in Q0.30
  function automatic exp_tab_t build_exp_table();
    longint unsigned e;
    exp_tab_t        t;
    e = longint'(1) << 30;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      t[i] = EXP_W'((e + 64'd8192) >> 14);
      e    = (e * longint'(EXP_BASE) + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

  typedef struct packed {
    logic                        cmd;
    logic [ID_W-1:0]             id;
    logic [15:0]                 dexc;
    logic [15:0]                 dinh;
    logic [15:0]                 dinhb;
    logic [15:0]                 ge;
    logic [15:0]                 gi;
    logic [15:0]                 gib;
    logic signed [15:0]          v;
    logic signed [15:0]          vth;
    logic signed [33:0]          pth;
    logic signed [15:0]          vth_new;
    logic [17:0]                 s;
    logic signed [32:0]          pe;
    logic signed [32:0]          pi;
    logic signed [32:0]          pib;
    logic signed [35:0]          n;
    logic [33:0]                 ks;
    logic signed [34:0]          vs;
    logic signed [36:0]          d;
    logic                        ti_ok;
    logic [EXP_IDX_W-1:0]        ti;
    logic signed [37:0]          num1;
    logic [18:0]                 den1;
    logic [32:0]                 dk_lo;
    logic signed [36:0]          dk_hi;
    logic [EXP_W-1:0]            ev;
    logic signed [18:0]          vinf;
    logic signed [17:0]          diff;
    logic signed [54:0]          xsum;
    logic signed [35:0]          pexact;
    logic signed [15:0]          v_exp;
    logic signed [43:0]          num2;
    logic [35:0]                 den2;
    logic signed [15:0]          vnew;
  } item_t;

endpackage

/* rtl/core/lif_neuron_update_unit.sv */
// Top level: conductance-based LIF neuron update pipeline with per-neuron state memory.
//
//   channel | direction | protocol       | word
//   in_     | input     | valid/ready    | tuser: cmd; tdata: neuron, drive_exc/inh/inh_slow
//   out_    | output    | valid/ready    | tdata: neuron_id, fired, membrane
//   cfg_    | input     | APB, 64b data  | six registers at 8-byte steps
//
// One word per cycle unless the output stalls or a hazard holds the input. A word passes
// stages 1-6, the equilibrium divider, Q1, Q2, the implicit Euler divider (both 18-stage)
// and R1. A word whose neuron is still anywhere in the pipeline waits at the input until
// that neuron's state is written back. Reset is synchronous; the state memory is not
// cleared. A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module lif_neuron_update_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // neuron[9:0], drive_exc, drive_inh, drive_inh_slow
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // neuron_id[9:0], fired, membrane
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import lnu_pkg::*;

  localparam int SAT_W = 56;

  function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] x);
    if (x > SAT_W'(32767))       return 16'sh7FFF;
    else if (x < SAT_W'(-32768)) return 16'sh8000;
    else                         return x[15:0];
  endfunction

  function automatic logic [15:0] cond_upd(input logic [15:0] g, input logic [15:0] drive,
                                           input logic [15:0] decay);
    logic [32:0] p;
    logic [17:0] v;
    p = 33'(g) * 33'(decay) + 33'd32768;
    v = 18'(p[32:16]) + 18'(drive);
    return (v > 18'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // configuration
  logic [1:0]  mode_r;
  logic [47:0] rev_r, rest_r, decay_r;
  logic [15:0] k_r, td_r;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd2;
      rev_r   <= '0;
      rest_r  <= '0;
      decay_r <= '0;
      k_r     <= 16'd655;
      td_r    <= 16'hFFFF;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_idx)
        REG_MODE:     mode_r  <= cfg_pwdata[1:0];
        REG_REVERSAL: rev_r   <= cfg_pwdata[47:0];
        REG_REST:     rest_r  <= cfg_pwdata[47:0];
        REG_DECAYS:   decay_r <= cfg_pwdata[47:0];
        REG_DT_TAU:   k_r     <= cfg_pwdata[15:0];
        REG_TH_DECAY: td_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:     cfg_prdata = 64'(mode_r);
      REG_REVERSAL: cfg_prdata = 64'(rev_r);
      REG_REST:     cfg_prdata = 64'(rest_r);
      REG_DECAYS:   cfg_prdata = 64'(decay_r);
      REG_DT_TAU:   cfg_prdata = 64'(k_r);
      REG_TH_DECAY: cfg_prdata = 64'(td_r);
      default:      cfg_prdata = '0;
    endcase
  end

  logic signed [15:0] vrest, vthrest, dvth, vexc, vinh, vinhb;
  assign vrest   = rest_r[15:0];
  assign vthrest = rest_r[31:16];
  assign dvth    = rest_r[47:32];
  assign vexc    = rev_r[15:0];
  assign vinh    = rev_r[31:16];
  assign vinhb   = rev_r[47:32];

  // pipeline control
  logic  en, hazard, accept;
  logic  p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r, p6_v_r, q1_v_r, q2_v_r, r1_v_r;
  item_t p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, q1_r, q2_r, r1_r;
  item_t p1_nxt, p2_nxt, p3_nxt, p4_nxt, p5_nxt, p6_nxt, q1_nxt, q2_nxt, r1_nxt;
  logic  out_valid_r;
  logic  [31:0] out_data_r;
  logic  [ID_W-1:0] in_id;
  logic  d1_hit, d2_hit, d1_valid, d2_valid;
  item_t d1_item, d2_item;
  logic signed [DIV_Q_W:0] d1_quo, d2_quo;

  assign in_id     = in_tdata[9:0];
  assign en        = !out_valid_r || out_tready;
  assign hazard    = (p1_v_r && p1_r.id == in_id) || (p2_v_r && p2_r.id == in_id) ||
                     (p3_v_r && p3_r.id == in_id) || (p4_v_r && p4_r.id == in_id) ||
                     (p5_v_r && p5_r.id == in_id) || (p6_v_r && p6_r.id == in_id) ||
                     (q1_v_r && q1_r.id == in_id) || (q2_v_r && q2_r.id == in_id) ||
                     (r1_v_r && r1_r.id == in_id) || d1_hit || d2_hit;
  assign in_tready = en && !hazard;
  assign accept    = in_tvalid && in_tready;

  // state memory: {v, vth, ge, gi, gib}
  logic [79:0] mem [NEURONS];
  logic [79:0] memq_r;
  logic        wr_en;
  logic [79:0] wr_data;

  always_ff @(posedge clk) begin
    if (en) memq_r <= mem[in_id];
    if (wr_en) mem[r1_r.id] <= wr_data;
  end

  // stage 1: capture the word
  always_comb begin
    p1_nxt       = p1_r;
    p1_nxt.cmd   = in_tuser;
    p1_nxt.id    = in_id;
    p1_nxt.dexc  = in_tdata[25:10];
    p1_nxt.dinh  = in_tdata[41:26];
    p1_nxt.dinhb = in_tdata[57:42];
  end

  // stage 2: conductance decay plus drive, threshold product
  logic signed [15:0] vth_m;
  logic signed [16:0] th_diff;
  assign vth_m   = memq_r[63:48];
  assign th_diff = 17'(vth_m) - 17'(vthrest);

  always_comb begin
    p2_nxt     = p1_r;
    p2_nxt.ge  = cond_upd(memq_r[47:32], p1_r.dexc, decay_r[15:0]);
    p2_nxt.gi  = cond_upd(memq_r[31:16], p1_r.dinh, decay_r[31:16]);
    p2_nxt.gib = cond_upd(memq_r[15:0], p1_r.dinhb, decay_r[47:32]);
    p2_nxt.v   = memq_r[79:64];
    p2_nxt.vth = vth_m;
    p2_nxt.pth = th_diff * $signed({1'b0, td_r});
  end

  // stage 3: total conductance, reversal products, threshold relaxation
  always_comb begin
    p3_nxt         = p2_r;
    p3_nxt.s       = 18'(G_ONE) + 18'(p2_r.ge) + 18'(p2_r.gi) + 18'(p2_r.gib);
    p3_nxt.pe      = $signed({1'b0, p2_r.ge}) * vexc;
    p3_nxt.pi      = $signed({1'b0, p2_r.gi}) * vinh;
    p3_nxt.pib     = $signed({1'b0, p2_r.gib}) * vinhb;
    p3_nxt.vth_new = sat16(SAT_W'(vthrest) + ((SAT_W'(p2_r.pth) + SAT_W'(32768)) >>> 16));
  end

  // stage 4: equilibrium numerator, k*S, V*S
  always_comb begin
    p4_nxt    = p3_r;
    p4_nxt.n  = (36'(vrest) <<< 8) + 36'(p3_r.pe) + 36'(p3_r.pi) + 36'(p3_r.pib);
    p4_nxt.ks = p3_r.s * k_r;
    p4_nxt.vs = p3_r.v * $signed({1'b0, p3_r.s});
  end

  // stage 5: explicit residual, table index, first divider operands
  logic [47:0] tiw;
  assign tiw = 48'(p4_r.ks) * 48'(EXP_DEPTH) + 48'(134217728);

  always_comb begin
    p5_nxt       = p4_r;
    p5_nxt.d     = 37'(p4_r.vs) - 37'(p4_r.n);
    p5_nxt.ti_ok = tiw[47:28] < 20'(EXP_DEPTH);
    p5_nxt.ti    = tiw[28 +: EXP_IDX_W];
    p5_nxt.num1  = (38'(p4_r.n) <<< 1) + 38'($signed({1'b0, p4_r.s}));
    p5_nxt.den1  = {p4_r.s, 1'b0};
  end

  // stage 6: residual times k in two partial products, exp lookup
  always_comb begin
    p6_nxt       = p5_r;
    p6_nxt.dk_lo = p5_r.d[16:0] * k_r;
    p6_nxt.dk_hi = $signed(p5_r.d[36:17]) * $signed({1'b0, k_r});
    p6_nxt.ev    = p5_r.ti_ok ? EXP_TABLE[p5_r.ti] : '0;
  end

  lnu_div u_div_vinf (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p6_v_r),
    .in_item   (p6_r),
    .num       (DIV_NUM_W'(p6_r.num1)),
    .den       (DIV_DEN_W'(p6_r.den1)),
    .probe_id  (in_id),
    .hit       (d1_hit),
    .out_valid (d1_valid),
    .out_item  (d1_item),
    .quo       (d1_quo)
  );

  // stage Q1: equilibrium, distance to it, explicit sum
  always_comb begin
    q1_nxt      = d1_item;
    q1_nxt.vinf = d1_quo;
    q1_nxt.diff = 18'(20'(d1_item.v) - 20'(d1_quo));
    q1_nxt.xsum = (55'(d1_item.dk_hi) <<< 17) + 55'($signed({1'b0, d1_item.dk_lo}));
  end

  // stage Q2: implicit divider operands, exact product, explicit result
  logic [34:0] imp_b;
  assign imp_b = 35'(q1_r.ks) + 35'(16777216);

  always_comb begin
    q2_nxt        = q1_r;
    q2_nxt.num2   = (44'(q1_r.diff) <<< 25) + 44'($signed({1'b0, imp_b}));
    q2_nxt.den2   = {imp_b, 1'b0};
    q2_nxt.pexact = q1_r.diff * $signed({1'b0, q1_r.ev});
    q2_nxt.v_exp  = sat16(SAT_W'(q1_r.v) -
                          ((SAT_W'(q1_r.xsum) + SAT_W'(8388608)) >>> 24));
  end

  lnu_div u_div_impl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q2_v_r),
    .in_item   (q2_r),
    .num       (q2_r.num2),
    .den       (q2_r.den2),
    .probe_id  (in_id),
    .hit       (d2_hit),
    .out_valid (d2_valid),
    .out_item  (d2_item),
    .quo       (d2_quo)
  );

  // stage R1: pick the integration result
  always_comb begin
    r1_nxt = d2_item;
    case (mode_r)
      MODE_EXPLICIT: r1_nxt.vnew = d2_item.v_exp;
      MODE_IMPLICIT: r1_nxt.vnew = sat16(SAT_W'(d2_item.vinf) + SAT_W'(d2_quo));
      default:       r1_nxt.vnew = sat16(SAT_W'(d2_item.vinf) +
                                         ((SAT_W'(d2_item.pexact) + SAT_W'(32768)) >>> 16));
    endcase
  end

  // final: clamp, spike test, write back
  logic               fire;
  logic [15:0]        gec, gic, gibc;
  logic signed [15:0] v_out, vth_out;

  always_comb begin
    gec  = (r1_r.ge > G_MAX) ? G_MAX : r1_r.ge;
    gic  = (r1_r.gi > G_MAX) ? G_MAX : r1_r.gi;
    gibc = (r1_r.gib > G_MAX) ? G_MAX : r1_r.gib;
    fire = (r1_r.cmd != CMD_INIT) && (r1_r.vnew > r1_r.vth_new);
    if (r1_r.cmd == CMD_INIT) begin
      v_out   = vrest;
      vth_out = vthrest;
      wr_data = {vrest, vthrest, 48'd0};
    end else if (fire) begin
      v_out   = vrest;
      vth_out = sat16(SAT_W'(r1_r.vth_new) + SAT_W'(dvth));
      wr_data = {vrest, vth_out, gec, gic, gibc + G_ONE};
    end else begin
      v_out   = r1_r.vnew;
      vth_out = r1_r.vth_new;
      wr_data = {r1_r.vnew, r1_r.vth_new, gec, gic, gibc};
    end
  end

  assign wr_en = en && r1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
      p5_v_r      <= 1'b0;
      p6_v_r      <= 1'b0;
      q1_v_r      <= 1'b0;
      q2_v_r      <= 1'b0;
      r1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_v_r      <= accept;
      p2_v_r      <= p1_v_r;
      p3_v_r      <= p2_v_r;
      p4_v_r      <= p3_v_r;
      p5_v_r      <= p4_v_r;
      p6_v_r      <= p5_v_r;
      q1_v_r      <= d1_valid;
      q2_v_r      <= q1_v_r;
      r1_v_r      <= d2_valid;
      out_valid_r <= r1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r       <= p1_nxt;
      p2_r       <= p2_nxt;
      p3_r       <= p3_nxt;
      p4_r       <= p4_nxt;
      p5_r       <= p5_nxt;
      p6_r       <= p6_nxt;
      q1_r       <= q1_nxt;
      q2_r       <= q2_nxt;
      r1_r       <= r1_nxt;
      out_data_r <= {5'd0, v_out, fire, r1_r.id};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/core/lnu_div.sv */
// Pipelined restoring divider, one quotient bit per stage, floor for signed dividends.
module lnu_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  lnu_pkg::item_t                       in_item,
  input  logic signed [lnu_pkg::DIV_NUM_W-1:0] num,
  input  logic [lnu_pkg::DIV_DEN_W-1:0]        den,
  input  logic [lnu_pkg::ID_W-1:0]             probe_id,
  output logic                                 hit,
  output logic                                 out_valid,
  output lnu_pkg::item_t                       out_item,
  output logic signed [lnu_pkg::DIV_Q_W:0]     quo
);
  import lnu_pkg::*;

  logic                 vld_r  [DIV_Q_W];
  item_t                item_r [DIV_Q_W];
  logic [DIV_NUM_W-1:0] rem_r  [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_r  [DIV_Q_W];
  logic [DIV_Q_W-1:0]   q_r    [DIV_Q_W];
  logic                 neg_r  [DIV_Q_W];

  logic                 vld_in  [DIV_Q_W];
  item_t                item_in [DIV_Q_W];
  logic [DIV_NUM_W-1:0] rem_in  [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_in  [DIV_Q_W];
  logic [DIV_Q_W-1:0]   q_in    [DIV_Q_W];
  logic                 neg_in  [DIV_Q_W];
  logic [DIV_NUM_W-1:0] rem_nxt [DIV_Q_W];
  logic [DIV_Q_W-1:0]   q_nxt   [DIV_Q_W];
  logic [DIV_Q_W-1:0]   match;

  for (genvar j = 0; j < DIV_Q_W; j++) begin : g_stage
    logic [DIV_CMP_W-1:0] trial;

    if (j == 0) begin : g_first
      // negative dividend: floor(a/b) = ~floor(~a/b)
      assign vld_in[j]  = in_valid;
      assign item_in[j] = in_item;
      assign neg_in[j]  = num[DIV_NUM_W-1];
      assign rem_in[j]  = num[DIV_NUM_W-1] ? ~num : num;
      assign den_in[j]  = den;
      assign q_in[j]    = '0;
    end else begin : g_next
      assign vld_in[j]  = vld_r[j-1];
      assign item_in[j] = item_r[j-1];
      assign neg_in[j]  = neg_r[j-1];
      assign rem_in[j]  = rem_r[j-1];
      assign den_in[j]  = den_r[j-1];
      assign q_in[j]    = q_r[j-1];
    end

    always_comb begin
      trial = DIV_CMP_W'(den_in[j]) << (DIV_Q_W - 1 - j);
      if (DIV_CMP_W'(rem_in[j]) >= trial) begin
        rem_nxt[j] = rem_in[j] - DIV_NUM_W'(trial);
        q_nxt[j]   = q_in[j] | (DIV_Q_W'(1) << (DIV_Q_W - 1 - j));
      end else begin
        rem_nxt[j] = rem_in[j];
        q_nxt[j]   = q_in[j];
      end
    end

    assign match[j] = vld_r[j] && (item_r[j].id == probe_id);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_Q_W; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < DIV_Q_W; j++) vld_r[j] <= vld_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_Q_W; j++) begin
        item_r[j] <= item_in[j];
        rem_r[j]  <= rem_nxt[j];
        den_r[j]  <= den_in[j];
        q_r[j]    <= q_nxt[j];
        neg_r[j]  <= neg_in[j];
      end
    end
  end

  assign hit       = |match;
  assign out_valid = vld_r[DIV_Q_W-1];
  assign out_item  = item_r[DIV_Q_W-1];
  assign quo       = neg_r[DIV_Q_W-1] ? ~$signed({1'b0, q_r[DIV_Q_W-1]})
                                      : $signed({1'b0, q_r[DIV_Q_W-1]});

endmodule

/* dv/lnu_checker.sv */
// Checker for the LIF neuron update unit: register shadow, state predictor and scoreboard.
module lnu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          n_fail,
  output int          n_pending,
  output int          n_spikes,
  output int          n_words
);
  import lnu_pkg::*;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic               fired;
    logic signed [15:0] membrane;
  } neuron_result_t;

  neuron_result_t result_q[$];

  logic [1:0]  sh_mode;
  logic [47:0] sh_reversal;
  logic [47:0] sh_rest;
  logic [47:0] sh_decays;
  logic [15:0] sh_dt_tau;
  logic [15:0] sh_th_decay;

  longint unsigned     decay_lut[EXP_DEPTH];
  logic signed [15:0]  v_mem[NEURONS];
  logic signed [15:0]  vth_mem[NEURONS];
  logic [15:0]         ge_mem[NEURONS];
  logic [15:0]         gi_mem[NEURONS];
  logic [15:0]         gib_mem[NEURONS];

  initial begin
    longint          term;
    longint          base;
    longint unsigned e;
    term = longint'(1) << 30;
    base = term;
    e    = longint'(1) << 30;
    for (int n = 1; n <= 24; n++) begin
      term = (term * 16) / (longint'(EXP_DEPTH) * n);
      if (n % 2 == 1) base = base - term;
      else base = base + term;
    end
    for (int i = 0; i < EXP_DEPTH; i++) begin
      decay_lut[i] = (e + 64'd8192) >> 14;
      e = (e * longint'(base) + (64'd1 << 29)) >> 30;
    end
    n_fail = 0;
    n_pending = 0;
    n_spikes = 0;
    n_words = 0;
  end

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint round_quot(longint a, longint b);
    return floor_quot(2 * a + b, 2 * b);
  endfunction

  function automatic longint clip16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint sext16(logic [15:0] x);
    return longint'(signed'(x));
  endfunction

  function automatic longint decay_cond(longint g, longint drive, longint dec);
    longint r;
    r = drive + ((g * dec + 32768) >>> 16);
    return (r > 65535) ? 65535 : r;
  endfunction

  // advance or initialize one neuron and return what the block should report
  function automatic neuron_result_t update_neuron(logic cmd, logic [ID_W-1:0] id,
                                                   logic [15:0] de, logic [15:0] di,
                                                   logic [15:0] dib);
    neuron_result_t r;
    longint vrest, vthrest, dvth, vexc, vinh, vinhb, k;
    longint ge, gi, gib, v, vth, s, n, vinf, ks, ti, ev;
    r.id = id;
    r.fired = 1'b0;
    vrest   = sext16(sh_rest[15:0]);
    vthrest = sext16(sh_rest[31:16]);
    dvth    = sext16(sh_rest[47:32]);
    vexc    = sext16(sh_reversal[15:0]);
    vinh    = sext16(sh_reversal[31:16]);
    vinhb   = sext16(sh_reversal[47:32]);
    k       = longint'(sh_dt_tau);
    if (cmd == CMD_INIT) begin
      v_mem[id] = vrest[15:0];
      vth_mem[id] = vthrest[15:0];
      ge_mem[id] = '0;
      gi_mem[id] = '0;
      gib_mem[id] = '0;
      r.membrane = vrest[15:0];
      return r;
    end
    ge  = decay_cond(ge_mem[id], de, sh_decays[15:0]);
    gi  = decay_cond(gi_mem[id], di, sh_decays[31:16]);
    gib = decay_cond(gib_mem[id], dib, sh_decays[47:32]);
    v   = sext16(v_mem[id]);
    vth = sext16(vth_mem[id]);
    s    = 256 + ge + gi + gib;
    n    = vrest * 256 + ge * vexc + gi * vinh + gib * vinhb;
    vinf = round_quot(n, s);
    ks   = k * s;
    if (sh_mode == MODE_EXPLICIT) begin
      v = clip16(v - round_quot((v * s - n) * k, longint'(1) << 24));
    end else if (sh_mode == MODE_IMPLICIT) begin
      v = clip16(vinf + round_quot((v - vinf) * (longint'(1) << 24),
                                   (longint'(1) << 24) + ks));
    end else begin
      ti = floor_quot(ks * EXP_DEPTH + (longint'(1) << 27), longint'(1) << 28);
      ev = (ti < EXP_DEPTH) ? longint'(decay_lut[ti]) : 0;
      v = clip16(vinf + round_quot((v - vinf) * ev, longint'(1) << 16));
    end
    vth = clip16(vthrest + round_quot((vth - vthrest) * longint'(sh_th_decay),
                                      longint'(1) << 16));
    if (ge > G_MAX) ge = G_MAX;
    if (gi > G_MAX) gi = G_MAX;
    if (gib > G_MAX) gib = G_MAX;
    if (v > vth) begin
      r.fired = 1'b1;
      v = vrest;
      gib = gib + G_ONE;
      vth = clip16(vth + dvth);
    end
    v_mem[id] = v[15:0];
    vth_mem[id] = vth[15:0];
    ge_mem[id] = ge[15:0];
    gi_mem[id] = gi[15:0];
    gib_mem[id] = gib[15:0];
    r.membrane = v[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    neuron_result_t want;
    logic [ID_W-1:0]    got_id;
    logic               got_fired;
    logic signed [15:0] got_mem;
    if (!rst_n) begin
      sh_mode     = 2'd2;
      sh_reversal = '0;
      sh_rest     = '0;
      sh_decays   = '0;
      sh_dt_tau   = 16'd655;
      sh_th_decay = 16'hffff;
      result_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[5:3])
          REG_MODE:     sh_mode     = cfg_pwdata[1:0];
          REG_REVERSAL: sh_reversal = cfg_pwdata[47:0];
          REG_REST:     sh_rest     = cfg_pwdata[47:0];
          REG_DECAYS:   sh_decays   = cfg_pwdata[47:0];
          REG_DT_TAU:   sh_dt_tau   = cfg_pwdata[15:0];
          REG_TH_DECAY: sh_th_decay = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        result_q.push_back(update_neuron(in_tuser, in_tdata[9:0], in_tdata[25:10],
                                         in_tdata[41:26], in_tdata[57:42]));
        n_words++;
      end
      if (out_tvalid && out_tready) begin
        got_id    = out_tdata[9:0];
        got_fired = out_tdata[10];
        got_mem   = out_tdata[26:11];
        if (result_q.size() == 0) begin
          $error("unexpected output word: neuron_id %0d", got_id);
          n_fail++;
        end else begin
          want = result_q.pop_front();
          if (got_id !== want.id) begin
            $error("neuron_id: expected %0d, actual %0d", want.id, got_id);
            n_fail++;
          end
          if (got_fired !== want.fired) begin
            $error("fired: expected %0d, actual %0d", want.fired, got_fired);
            n_fail++;
          end
          if (got_mem !== want.membrane) begin
            $error("membrane: expected %0d, actual %0d", want.membrane, got_mem);
            n_fail++;
          end
          if (want.fired) n_spikes++;
        end
      end
    end
    n_pending = result_q.size();
  end

endmodule

/* dv/tb_top.sv */
// Stimulus and verdict for the LIF neuron update unit.
module tb_top;
  import lnu_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // neuron[9:0], drive_exc, drive_inh, drive_inh_slow
  logic        in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // neuron_id[9:0], fired, membrane
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int n_fail, n_pending, n_spikes, n_words;
  bit allow_idle;
  bit ready_map[NEURONS];

  localparam int PIPE_LAT = 60;

  lif_neuron_update_unit u_top (.*);

  lnu_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .n_fail, .n_pending, .n_spikes, .n_words
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver back-pressure in bursts
  initial begin
    int hold;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) out_tready = 1'b1;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 10);
        out_tready = 1'b0;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 3'b000};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (PIPE_LAT) @(negedge clk);
  endtask

  task automatic send_word(logic cmd, logic [9:0] id, logic [15:0] de, logic [15:0] di,
                           logic [15:0] dib);
    if (allow_idle && $urandom_range(0, 9) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {6'b0, dib, di, de, id};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_INIT) ready_map[id] = 1'b1;
  endtask

  function automatic logic [15:0] pick_drive();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'h0000;
      default: return 16'($urandom_range(0, 16'h0300));
    endcase
  endfunction

  // one neuron of a small hot set most of the time, so the state history runs deep
  task automatic random_word();
    logic [9:0] id;
    if ($urandom_range(0, 4) != 0) id = 10'($urandom_range(0, 23) ^ (($urandom & 1) * 10'h3e0));
    else id = 10'($urandom);
    if (!ready_map[id] || $urandom_range(0, 24) == 0)
      send_word(CMD_INIT, id, 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_word(1'b0, id, pick_drive(), pick_drive(), pick_drive());
  endtask

  function automatic logic [15:0] small_q88(int lo, int hi);
    int x;
    x = $urandom_range(0, hi - lo) + lo;
    return 16'(x);
  endfunction

  task automatic load_settings(int ph);
    logic [47:0] rev, rst, dec;
    logic [15:0] dt, thd;
    if (ph == 1) begin
      rev = 48'hffff_ffff_ffff; rst = 48'hffff_ffff_ffff; dec = 48'hffff_ffff_ffff;
      dt = 16'hffff; thd = 16'hffff;
    end else if (ph == 2) begin
      rev = {16'h8000, 16'h8000, 16'h7fff}; rst = {16'h7fff, 16'h8000, 16'h8000};
      dec = '0; dt = 16'h0000; thd = 16'h0000;
    end else if (ph == 5) begin
      rev = {16'($urandom), 32'($urandom)};
      rst = {16'($urandom), 32'($urandom)};
      dec = {16'($urandom), 32'($urandom)};
      dt = 16'($urandom); thd = 16'($urandom);
    end else begin
      // roughly physiological: excitation above threshold, inhibition below rest
      rev = {small_q88(-4096, 0), small_q88(-4096, 0), small_q88(256, 8192)};
      rst = {small_q88(0, 1024), small_q88(0, 768), small_q88(-256, 256)};
      dec = {16'($urandom_range(0, 16'hffff)), 16'($urandom_range(16'h8000, 16'hffff)),
             16'($urandom_range(16'hc000, 16'hffff))};
      dt = 16'($urandom_range(16, 16'h4000)); thd = 16'($urandom_range(16'hc000, 16'hffff));
    end
    reg_write(REG_MODE, 64'(ph % 4));
    reg_write(REG_REVERSAL, {16'b0, rev});
    reg_write(REG_REST, {16'b0, rst});
    reg_write(REG_DECAYS, {16'b0, dec});
    reg_write(REG_DT_TAU, {48'b0, dt});
    reg_write(REG_TH_DECAY, {48'b0, thd});
  endtask

  initial begin
    int n_phases;
    n_phases = 7;
    allow_idle = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset register values first, then a firing setup
    send_word(CMD_INIT, 10'd0, 16'hffff, 16'hffff, 16'hffff);
    send_word(1'b0, 10'd0, 16'h0100, 16'h0000, 16'h0000);
    drain();
    reg_write(REG_MODE, 64'(MODE_EXPLICIT));
    reg_write(REG_REVERSAL, {16'b0, 16'hf000, 16'hf800, 16'h0800});
    reg_write(REG_REST, {16'b0, 16'h0040, 16'h0100, 16'h0000});
    reg_write(REG_DECAYS, {16'b0, 16'hf000, 16'he000, 16'hc000});
    reg_write(REG_DT_TAU, 64'd8000);
    reg_write(REG_TH_DECAY, 64'hf000);
    send_word(CMD_INIT, 10'd1023, '0, '0, '0);
    send_word(CMD_INIT, 10'd512, '0, '0, '0);
    send_word(CMD_INIT, 10'd341, '0, '0, '0);
    send_word(1'b0, 10'd1023, 16'hffff, 16'hffff, 16'hffff);
    send_word(1'b0, 10'd512, 16'h0000, 16'h0000, 16'h0000);
    send_word(1'b0, 10'd341, 16'haaaa, 16'h5555, 16'h0000);
    for (int i = 0; i < 6; i++) send_word(1'b0, 10'd0, 16'h0a00, 16'h0000, 16'h0000);
    send_word(1'b0, 10'd512, 16'h0000, 16'hffff, 16'h0000);
    send_word(1'b0, 10'd512, 16'h0000, 16'h0000, 16'hffff);
    send_word(CMD_INIT, 10'd0, 16'h1234, 16'h5678, 16'h9abc);
    send_word(1'b0, 10'd0, 16'h0a00, 16'h0000, 16'h0000);
    drain();

    for (int ph = 0; ph < n_phases; ph++) begin
      load_settings(ph);
      if (ph == n_phases - 1) allow_idle = 1'b0;
      for (int i = 0; i < 195; i++) random_word();
      drain();
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    drain();
    $display("words accepted: %0d, spikes seen: %0d, over %0d register settings",
             n_words, n_spikes, n_phases + 2);
    $display("integration modes 0..3 and extreme register values exercised");
    if (n_fail == 0 && n_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
